// File: hw/rtl/oblt_pkg.sv
// ----------------------------------------------------------------------------
// oblt_pkg
// Shared types and codes for the order book level table.
// ----------------------------------------------------------------------------
package oblt_pkg;

  localparam logic [1:0] OP_SNAPSHOT = 2'd0;
  localparam logic [1:0] OP_DELTA    = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic [1:0] ST_APPLIED = 2'd0;
  localparam logic [1:0] ST_STALE   = 2'd1;
  localparam logic [1:0] ST_GAP     = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic        event_start;
    logic        level_present;
    logic        book_side;
    logic [31:0] level_price;
    logic [31:0] level_size;
    logic [63:0] event_sequence;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] best_bid_price;
    logic [31:0] best_bid_size;
    logic        bid_present;
    logic [31:0] best_ask_price;
    logic [31:0] best_ask_size;
    logic        ask_present;
    logic        crossed;
    logic [32:0] mid_doubled;
    logic [63:0] current_sequence;
  } result_t;

  // Classified command from the front end to the table engine.
  typedef struct packed {
    logic        clear_book;
    logic        apply_level;
    logic        removes;
    logic        book_side;
    logic [31:0] level_price;
    logic [31:0] level_size;
    logic [1:0]  status;
    logic [63:0] current_sequence;
  } cmd_t;

endpackage

// File: hw/rtl/order_book_level_table.sv
// ----------------------------------------------------------------------------
// order_book_level_table
// Two sorted price-level tables with sequence checking and top-of-book report.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item) takes one level word of a
//   market event; result channel (result_valid/result_ready/result) returns
//   one word per item: status, best bid and ask, crossed flag, doubled mid
//   and the current sequence.
//   The front end checks sequences and classifies each word, then pushes a
//   command into a two-entry queue; it takes a word in the cycle it arrives
//   while the queue has room.
//   The table engine takes each command through its steps in turn (take,
//   compare all entries, shift and report) and accepts no new command until
//   the last one has reported, so the engine sets the sustained rate.
//   Reset empties both sides, zeroes the sequence and clears pending words.
//   A stalled receiver holds the result register; the engine then waits,
//   the queue fills and item_ready drops.
// ----------------------------------------------------------------------------
module order_book_level_table import oblt_pkg::*; #(
  parameter int LEVELS_PER_SIDE = 64
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic fq_valid, fq_ready, qt_valid, qt_ready;
  cmd_t fq_cmd, qt_cmd;

  // Classify: sequence check and event state.
  oblt_front u_front (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .cmd_valid(fq_valid), .cmd_ready(fq_ready), .cmd(fq_cmd)
  );

  // Decouple front and back.
  oblt_cmd_queue u_queue (
    .clk(clk), .rst(rst),
    .push_valid(fq_valid), .push_ready(fq_ready), .push_cmd(fq_cmd),
    .pop_valid(qt_valid), .pop_ready(qt_ready), .pop_cmd(qt_cmd)
  );

  // Carry out: sorted table update and report.
  oblt_table #(.LEVELS_PER_SIDE(LEVELS_PER_SIDE)) u_table (
    .clk(clk), .rst(rst),
    .cmd_valid(qt_valid), .cmd_ready(qt_ready), .cmd(qt_cmd),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

endmodule

// File: hw/rtl/oblt_front.sv
// ----------------------------------------------------------------------------
// oblt_front
// Sequence check and event tracking; turns each word into a table command.
// ----------------------------------------------------------------------------
module oblt_front import oblt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  output logic  cmd_valid,
  input  logic  cmd_ready,
  output cmd_t  cmd
);

  logic [63:0] last_sequence, last_sequence_next;
  logic        event_accepted, event_accepted_next;
  logic [1:0]  event_status, event_status_next;

  assign item_ready = cmd_ready;
  assign cmd_valid  = item_valid;

  always_comb begin
    last_sequence_next  = last_sequence;
    event_accepted_next = event_accepted;
    event_status_next   = event_status;
    cmd                 = '0;
    cmd.book_side       = item.book_side;
    cmd.level_price     = item.level_price;
    cmd.level_size      = item.level_size;
    cmd.removes         = (item.operation == OP_DELTA);
    if (item.operation == OP_CLEAR) begin
      last_sequence_next  = '0;
      event_accepted_next = 1'b0;
      event_status_next   = ST_APPLIED;
      cmd.clear_book      = 1'b1;
    end else if (item.operation inside {OP_SNAPSHOT, OP_DELTA}) begin
      if (item.event_start) begin
        if (item.operation == OP_SNAPSHOT) begin
          last_sequence_next  = item.event_sequence;
          event_accepted_next = 1'b1;
          event_status_next   = ST_APPLIED;
          cmd.clear_book      = 1'b1;
        end else if (item.event_sequence <= last_sequence) begin
          event_accepted_next = 1'b0;
          event_status_next   = ST_STALE;
        end else if (item.event_sequence != last_sequence + 64'd1) begin
          event_accepted_next = 1'b0;
          event_status_next   = ST_GAP;
        end else begin
          last_sequence_next  = item.event_sequence;
          event_accepted_next = 1'b1;
          event_status_next   = ST_APPLIED;
        end
      end
      if (!event_accepted_next) begin
        cmd.status = event_status_next;
      end else begin
        cmd.apply_level = item.level_present;
      end
    end
    cmd.current_sequence = last_sequence_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sequence  <= '0;
      event_accepted <= 1'b0;
      event_status   <= ST_APPLIED;
    end else if (item_valid && item_ready) begin
      last_sequence  <= last_sequence_next;
      event_accepted <= event_accepted_next;
      event_status   <= event_status_next;
    end
  end

endmodule

// File: hw/rtl/oblt_cmd_queue.sv
// ----------------------------------------------------------------------------
// oblt_cmd_queue
// Two-entry command queue between the front end and the table engine.
// ----------------------------------------------------------------------------
module oblt_cmd_queue import oblt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic       do_push, do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// File: hw/rtl/oblt_table.sv
// ----------------------------------------------------------------------------
// oblt_table
// Sorted shift tables for both sides; compare cycle then update cycle.
// ----------------------------------------------------------------------------
module oblt_table import oblt_pkg::*; #(
  parameter int LEVELS_PER_SIDE = 64
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  output logic    cmd_ready,
  input  cmd_t    cmd,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int N  = LEVELS_PER_SIDE;
  localparam int CW = $clog2(N + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOAD = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t        state;
  cmd_t          cmd_q;
  logic [N-1:0]  match_q, better_q;
  logic [31:0]   prices [2][N];
  logic [31:0]   sizes  [2][N];
  logic [CW-1:0] cnt [2];

  logic [31:0]   prices_next [2][N];
  logic [31:0]   sizes_next  [2][N];
  logic [CW-1:0] cnt_next [2];
  logic [N-1:0]  valid_v, keep;
  logic [CW-1:0] n;
  logic          found, ins, rem, ovw, full;
  logic          sd;
  logic          bp, ap;
  logic [31:0]   bbp, bbs, bap, bas;

  assign cmd_ready = (state == S_IDLE) && (!result_valid || result_ready);
  assign sd        = cmd_q.book_side;

  always_comb begin
    prices_next = prices;
    sizes_next  = sizes;
    cnt_next    = cnt;
    n           = cnt[sd];
    for (int i = 0; i < N; i++) begin
      valid_v[i] = (CW'(i) < n);
    end
    found = |(match_q & valid_v);
    keep  = better_q & valid_v;
    ins   = cmd_q.apply_level && (cmd_q.level_size != '0) && !found && (n != CW'(N));
    full  = cmd_q.apply_level && (cmd_q.level_size != '0) && !found && (n == CW'(N));
    rem   = cmd_q.apply_level && found && (cmd_q.level_size == '0) && cmd_q.removes;
    ovw   = cmd_q.apply_level && found && (cmd_q.level_size != '0);
    // Insert: entries after the slot move down by one.
    for (int i = 1; i < N; i++) begin
      if (ins && !keep[i] && !keep[i-1]) begin
        prices_next[sd][i] = prices[sd][i-1];
        sizes_next[sd][i]  = sizes[sd][i-1];
      end
    end
    for (int i = 0; i < N; i++) begin
      if (ins && !keep[i] && (i == 0 || keep[(i == 0) ? 0 : i-1])) begin
        prices_next[sd][i] = cmd_q.level_price;
        sizes_next[sd][i]  = cmd_q.level_size;
      end
      if (ovw && match_q[i] && valid_v[i]) begin
        sizes_next[sd][i] = cmd_q.level_size;
      end
    end
    // Remove: entries from the match onwards move up by one.
    for (int i = 0; i < N - 1; i++) begin
      if (rem && !keep[i]) begin
        prices_next[sd][i] = prices[sd][i+1];
        sizes_next[sd][i]  = sizes[sd][i+1];
      end
    end
    if (ins) cnt_next[sd] = n + CW'(1);
    if (rem) cnt_next[sd] = n - CW'(1);
    bp  = (cnt_next[0] != '0);
    ap  = (cnt_next[1] != '0);
    bbp = bp ? prices_next[0][0] : '0;
    bbs = bp ? sizes_next[0][0]  : '0;
    bap = ap ? prices_next[1][0] : '0;
    bas = ap ? sizes_next[1][0]  : '0;
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (cmd_valid && cmd_ready) cmd_q <= cmd;
      end
      S_LOAD: begin
        for (int i = 0; i < N; i++) begin
          match_q[i]  <= (prices[sd][i] == cmd_q.level_price);
          better_q[i] <= sd ? (prices[sd][i] < cmd_q.level_price)
                            : (prices[sd][i] > cmd_q.level_price);
        end
      end
      S_EXEC: begin
        prices                  <= prices_next;
        sizes                   <= sizes_next;
        result.status           <= full ? ST_FULL : cmd_q.status;
        result.best_bid_price   <= bbp;
        result.best_bid_size    <= bbs;
        result.bid_present      <= bp;
        result.best_ask_price   <= bap;
        result.best_ask_size    <= bas;
        result.ask_present      <= ap;
        result.crossed          <= bp && ap && (bbp >= bap);
        result.mid_doubled      <= (bp && ap) ? ({1'b0, bbp} + {1'b0, bap}) : '0;
        result.current_sequence <= cmd_q.current_sequence;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      cnt[0]       <= '0;
      cnt[1]       <= '0;
    end else begin
      if (result_valid && result_ready) result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) state <= S_LOAD;
        end
        S_LOAD: begin
          // Empty both sides before the level lands.
          if (cmd_q.clear_book) begin
            cnt[0] <= '0;
            cnt[1] <= '0;
          end
          state <= S_EXEC;
        end
        S_EXEC: begin
          cnt          <= cnt_next;
          result_valid <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_bid_bound: assert property (@(posedge clk) disable iff (rst) cnt[0] <= CW'(N))
    else $error("bid count above depth");
  a_ask_bound: assert property (@(posedge clk) disable iff (rst) cnt[1] <= CW'(N))
    else $error("ask count above depth");
  a_bid_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.bid_present == (cnt[0] != '0)))
    else $error("bid present flag disagrees with table");
  a_ask_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.ask_present == (cnt[1] != '0)))
    else $error("ask present flag disagrees with table");
`endif

endmodule
